### rtl/tlht_pkg.sv
// Package: shared types and constants for the timestamp LRU handle table.
`default_nettype none

package tlht_pkg;

    localparam int KEY_W   = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RESET = 4'd10;

    // Table select codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Input beat
    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] table_key;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } res_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Sequencer controls
    typedef struct packed {
        logic accept;
        logic issue;
        logic commit;
    } ctl_t;

    // Store write controls
    typedef struct packed {
        logic key_we;
        logic stamp_we;
        logic valid_set;
        logic valid_clr;
        logic stamp_wipe;
    } wr_t;

    // Scan tracker flags
    typedef struct packed {
        logic found;
        logic min_vld;
        logic vic_vld;
        logic free_vld;
    } scan_flags_t;

endpackage

`default_nettype wire

### rtl/tlht_store.sv
// Entry store: key and stamp memories, valid bits and stamp-cleared flags.
`default_nettype none

module tlht_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic                             rd_valid,
    output logic [tlht_pkg::KEY_W-1:0]       rd_key,
    output logic [tlht_pkg::STAMP_W-1:0]     rd_stamp,
    input  wire tlht_pkg::wr_t               wr,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [AW-1:0]               clr_addr,
    input  wire logic [tlht_pkg::KEY_W-1:0]  wr_key,
    input  wire logic [tlht_pkg::STAMP_W-1:0] wr_stamp
);
    import tlht_pkg::*;

    logic [KEY_W-1:0]   key_mem   [DEPTH];
    logic [STAMP_W-1:0] stamp_mem [DEPTH];
    logic [KEY_W-1:0]   key_q;
    logic [STAMP_W-1:0] stamp_q;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   zero_reg;
    logic               valid_q;
    logic               zero_q;

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr.stamp_we)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            key_q   <= key_mem[rd_addr];
            stamp_q <= stamp_mem[rd_addr];
        end
    end

    // Track valid bits and wiped stamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            zero_reg  <= '0;
            valid_q   <= 1'b0;
            zero_q    <= 1'b0;
        end
        else
        begin
            if (wr.valid_clr)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
            if (wr.valid_set)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (wr.stamp_wipe)
            begin
                zero_reg <= '1;
            end
            else if (wr.stamp_we)
            begin
                zero_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                valid_q <= valid_reg[rd_addr];
                zero_q  <= zero_reg[rd_addr];
            end
        end
    end

    assign rd_valid = valid_q;
    assign rd_key   = key_q;
    assign rd_stamp = zero_q ? '0 : stamp_q;

endmodule

`default_nettype wire

### rtl/tlht_scan.sv
// Scan unit: shared compare datapath that tracks hit, min key, victim and free slot.
`default_nettype none

module tlht_scan #(
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic                         issue,
    input  wire logic [IW-1:0]                issue_idx,
    input  wire logic [tlht_pkg::KEY_W-1:0]   req_key,
    input  wire logic [tlht_pkg::STAMP_W-1:0] stamp_init,
    input  wire logic                         ent_valid,
    input  wire logic [tlht_pkg::KEY_W-1:0]   ent_key,
    input  wire logic [tlht_pkg::STAMP_W-1:0] ent_stamp,
    output tlht_pkg::scan_flags_t             flags,
    output logic [CW-1:0]                     count,
    output logic [IW-1:0]                     found_idx,
    output logic [IW-1:0]                     min_idx,
    output logic [tlht_pkg::KEY_W-1:0]        min_key,
    output logic [IW-1:0]                     vic_idx,
    output logic [tlht_pkg::KEY_W-1:0]        vic_key,
    output logic [IW-1:0]                     free_idx
);
    import tlht_pkg::*;

    logic                cmp_en_reg;
    logic [IW-1:0]       cmp_idx_reg;
    scan_flags_t         flags_reg;
    logic [CW-1:0]       count_reg;
    logic [IW-1:0]       found_idx_reg;
    logic [IW-1:0]       min_idx_reg;
    logic [KEY_W-1:0]    min_key_reg;
    logic [IW-1:0]       vic_idx_reg;
    logic [KEY_W-1:0]    vic_key_reg;
    logic [STAMP_W-1:0]  vic_stamp_reg;
    logic [IW-1:0]       free_idx_reg;
    logic                take_min;
    logic                take_vic;

    // Compare the returning entry against the trackers
    always_comb
    begin
        take_min = !flags_reg.min_vld || (ent_key < min_key_reg);
        take_vic = (ent_stamp < vic_stamp_reg) ||
                   (flags_reg.vic_vld && (ent_stamp == vic_stamp_reg) &&
                    (ent_key < vic_key_reg));
    end

    // Delay the read issue to line up with memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg <= 1'b0;
            flags_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cmp_en_reg <= issue;
            if (clear)
            begin
                flags_reg <= '0;
                count_reg <= '0;
            end
            else if (cmp_en_reg)
            begin
                if (ent_valid)
                begin
                    count_reg <= count_reg + CW'(1);
                    if (ent_key == req_key)
                    begin
                        flags_reg.found <= 1'b1;
                    end
                    if (take_min)
                    begin
                        flags_reg.min_vld <= 1'b1;
                    end
                    if (take_vic)
                    begin
                        flags_reg.vic_vld <= 1'b1;
                    end
                end
                else
                begin
                    flags_reg.free_vld <= 1'b1;
                end
            end
        end
    end

    // Hold tracker payloads
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= issue_idx;
        if (clear)
        begin
            vic_stamp_reg <= stamp_init;
        end
        else if (cmp_en_reg)
        begin
            if (ent_valid)
            begin
                if (ent_key == req_key)
                begin
                    found_idx_reg <= cmp_idx_reg;
                end
                if (take_min)
                begin
                    min_idx_reg <= cmp_idx_reg;
                    min_key_reg <= ent_key;
                end
                if (take_vic)
                begin
                    vic_idx_reg   <= cmp_idx_reg;
                    vic_key_reg   <= ent_key;
                    vic_stamp_reg <= ent_stamp;
                end
            end
            else if (!flags_reg.free_vld)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    assign flags     = flags_reg;
    assign count     = count_reg;
    assign found_idx = found_idx_reg;
    assign min_idx   = min_idx_reg;
    assign min_key   = min_key_reg;
    assign vic_idx   = vic_idx_reg;
    assign vic_key   = vic_key_reg;
    assign free_idx  = free_idx_reg;

endmodule

`default_nettype wire

### rtl/tlht_ctrl.sv
// Sequencer: steps one request through accept, table scan, drain and commit.
`default_nettype none

module tlht_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output tlht_pkg::ctl_t ctl,
    output logic [IW-1:0] rd_idx
);
    import tlht_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [IW-1:0] rd_idx_reg;
    logic [IW-1:0] rd_idx_next;
    logic          last;

    assign last = (rd_idx_reg == IW'(ENTRIES - 1));

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_idx_next = rd_idx_reg + IW'(1);
                if (last)
                begin
                    state_next  = ST_DRAIN;
                    rd_idx_next = '0;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        ctl.accept = (state_reg == ST_IDLE) && start;
        ctl.issue  = (state_reg == ST_SCAN);
        ctl.commit = (state_reg == ST_COMMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign rd_idx = rd_idx_reg;

endmodule

`default_nettype wire

### rtl/timestamp_lru_handle_table.sv
// Top level: two LRU handle tables under one request counter.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+------------------------------------
//  command  | start, busy, cmd          | beat taken when start && !busy
//  result   | done, result              | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready,     | beat taken when cfg_valid &&
//           | cfg_data                  | cfg_ready (ready always high)
//
// After a start is taken, busy stays high through the scan, drain and commit
// states: one memory read per entry of the chosen table through the
// shared compare unit, a drain state for the last read, a commit state.
// The result strobe follows in the cycle after commit, in which busy is low
// and a new start is taken, so requests never overlap: a new request is
// taken only once the previous one has left commit.
// Reset clears the counter, all valid bits and the sequencer at once.
// The receiver cannot stall; busy is the only hold on the command side.
`default_nettype none

module timestamp_lru_handle_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tlht_pkg::cmd_t                cmd,
    output logic                               done,
    output tlht_pkg::res_t                     result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tlht_pkg::LIMIT_W-1:0]  cfg_data
);
    import tlht_pkg::*;

    localparam int DEPTH = 2 * TABLE_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;

    ctl_t               ctl;
    logic [IW-1:0]      rd_idx;
    logic               tbl_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [STAMP_W-1:0] counter_reg;
    logic [STAMP_W-1:0] counter_inc;
    logic [LIMIT_W-1:0] open_limit_reg;
    logic               done_reg;
    res_t               res_reg;
    res_t               res_next;

    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [STAMP_W-1:0] rd_stamp;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      clr_addr;
    wr_t                wr;

    scan_flags_t        flags;
    logic [CW-1:0]      count;
    logic [IW-1:0]      found_idx;
    logic [IW-1:0]      min_idx;
    logic [KEY_W-1:0]   min_key;
    logic [IW-1:0]      vic_idx;
    logic [KEY_W-1:0]   vic_key;
    logic [IW-1:0]      free_idx;

    logic               need_evict;
    logic               do_evict;
    logic [IW-1:0]      evict_idx;
    logic [IW-1:0]      ins_idx;
    logic [IW-1:0]      wr_idx;

    assign counter_inc = counter_reg + STAMP_W'(1);
    assign cfg_ready   = 1'b1;

    tlht_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .ctl    (ctl),
        .rd_idx (rd_idx)
    );

    // Map a table slot to a store address
    always_comb
    begin
        rd_addr  = tbl_reg ? (AW'(TABLE_ENTRIES) + AW'(rd_idx)) : AW'(rd_idx);
        wr_addr  = tbl_reg ? (AW'(TABLE_ENTRIES) + AW'(wr_idx)) : AW'(wr_idx);
        clr_addr = tbl_reg ? (AW'(TABLE_ENTRIES) + AW'(evict_idx)) : AW'(evict_idx);
    end

    tlht_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (ctl.issue),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_stamp (rd_stamp),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .clr_addr (clr_addr),
        .wr_key   (key_reg),
        .wr_stamp (counter_reg)
    );

    tlht_scan #(
        .IW (IW),
        .CW (CW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (ctl.accept),
        .issue      (ctl.issue),
        .issue_idx  (rd_idx),
        .req_key    (key_reg),
        .stamp_init (counter_inc),
        .ent_valid  (rd_valid),
        .ent_key    (rd_key),
        .ent_stamp  (rd_stamp),
        .flags      (flags),
        .count      (count),
        .found_idx  (found_idx),
        .min_idx    (min_idx),
        .min_key    (min_key),
        .vic_idx    (vic_idx),
        .vic_key    (vic_key),
        .free_idx   (free_idx)
    );

    // Decide hit, eviction and insertion slot at commit
    always_comb
    begin
        need_evict = (CMPW'(count) > CMPW'(open_limit_reg)) ||
                     (count == CW'(TABLE_ENTRIES));
        do_evict   = !flags.found && need_evict && (flags.vic_vld || flags.min_vld);
        evict_idx  = flags.vic_vld ? vic_idx : min_idx;
        if (do_evict && !(flags.free_vld && (free_idx < evict_idx)))
        begin
            ins_idx = evict_idx;
        end
        else
        begin
            ins_idx = free_idx;
        end
        wr_idx = flags.found ? found_idx : ins_idx;

        wr.key_we     = ctl.commit && !flags.found;
        wr.stamp_we   = ctl.commit;
        wr.valid_set  = ctl.commit && !flags.found;
        wr.valid_clr  = ctl.commit && do_evict;
        wr.stamp_wipe = ctl.commit && (counter_reg == '0);

        res_next.hit         = flags.found;
        res_next.slot        = SLOT_W'(wr_idx);
        res_next.evicted     = do_evict;
        res_next.evicted_key = do_evict ? (flags.vic_vld ? vic_key : min_key) : '0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            open_limit_reg <= OPEN_LIMIT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.commit;
            if (ctl.accept)
            begin
                counter_reg <= counter_inc;
            end
            if (cfg_valid && cfg_ready)
            begin
                open_limit_reg <= cfg_data;
            end
        end
    end

    // Capture the request and the result beat
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            tbl_reg <= (cmd.opcode == OP_WRITE);
            key_reg <= cmd.table_key;
        end
        if (ctl.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for the timestamp LRU handle table: directed table then randomized phases.
`timescale 1ns / 100ps

module tb_top;

    import tlht_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 232;

    // Sender pacing per phase
    typedef enum int {
        PACE_FULL,
        PACE_SPARSE,
        PACE_MIXED
    } pace_t;

    // One row of the directed table
    typedef struct packed {
        logic                is_cfg;
        logic [LIMIT_W-1:0]  limit;
        cmd_t                cmd;
        logic                typed;
        res_t                res;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cmd_t                cmd;
    logic                done;
    res_t                result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data;

    // Shadow copy of both tables and the shared counter
    logic                shadow_valid [2*TABLE_ENTRIES];
    logic [KEY_W-1:0]    shadow_key   [2*TABLE_ENTRIES];
    logic [STAMP_W-1:0]  shadow_stamp [2*TABLE_ENTRIES];
    logic [STAMP_W-1:0]  shadow_count;
    logic [LIMIT_W-1:0]  shadow_limit;

    res_t                pending_res [$];
    int                  err_count;
    int                  idle_cycles;
    step_t               plan [$];

    timestamp_lru_handle_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Look up one key, restamp or insert, and return the result beat
    task automatic lru_lookup(input cmd_t c, output res_t r);
        int base;
        int found;
        int victim;
        int min_key;
        int cnt;
        int v;
        int fi;
        int e;
        logic [STAMP_W-1:0] vstamp;
        base    = (c.opcode == OP_WRITE) ? TABLE_ENTRIES : 0;
        found   = -1;
        victim  = -1;
        min_key = -1;
        cnt     = 0;
        r       = '0;
        shadow_count = shadow_count + 1;
        vstamp  = shadow_count;
        // scan the selected table for hit, oldest stamp and smallest key
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            e = base + i;
            if (shadow_valid[e])
            begin
                cnt++;
                if (shadow_key[e] == c.table_key)
                    found = i;
                if (min_key < 0 || shadow_key[e] < shadow_key[base + min_key])
                    min_key = i;
                if (shadow_stamp[e] < vstamp ||
                    (victim >= 0 && shadow_stamp[e] == vstamp &&
                     shadow_key[e] < shadow_key[base + victim]))
                begin
                    victim = i;
                    vstamp = shadow_stamp[e];
                end
            end
        end
        if (found >= 0)
        begin
            r.hit  = 1'b1;
            r.slot = SLOT_W'(found);
            shadow_stamp[base + found] = shadow_count;
        end
        else
        begin
            // evict when over the limit or when the table is full
            if (cnt > int'(shadow_limit) || cnt >= TABLE_ENTRIES)
            begin
                v = (victim >= 0) ? victim : min_key;
                if (v >= 0)
                begin
                    r.evicted     = 1'b1;
                    r.evicted_key = shadow_key[base + v];
                    shadow_valid[base + v] = 1'b0;
                end
            end
            // take the lowest free slot
            fi = 0;
            while (fi < TABLE_ENTRIES && shadow_valid[base + fi])
                fi++;
            if (fi >= TABLE_ENTRIES)
                fi = 0;
            r.slot = SLOT_W'(fi);
            shadow_valid[base + fi] = 1'b1;
            shadow_key[base + fi]   = c.table_key;
            shadow_stamp[base + fi] = shadow_count;
        end
        // wipe all stamps once the counter wraps
        if (shadow_count == '0)
        begin
            for (int i = 0; i < 2*TABLE_ENTRIES; i++)
                shadow_stamp[i] = '0;
        end
    endtask

    function automatic step_t cmd_row(input logic op, input logic [KEY_W-1:0] key);
        step_t s;
        s = '0;
        s.cmd.opcode    = op;
        s.cmd.table_key = key;
        return s;
    endfunction

    function automatic step_t typed_row(input logic op, input logic [KEY_W-1:0] key,
                                        input logic h, input logic [SLOT_W-1:0] sl,
                                        input logic ev, input logic [KEY_W-1:0] ek);
        step_t s;
        s = cmd_row(op, key);
        s.typed           = 1'b1;
        s.res.hit         = h;
        s.res.slot        = sl;
        s.res.evicted     = ev;
        s.res.evicted_key = ek;
        return s;
    endfunction

    function automatic step_t cfg_row(input logic [LIMIT_W-1:0] lim);
        step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.limit  = lim;
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // Draw an idle gap for the given pacing
    function automatic int draw_gap(input pace_t pace);
        int pct;
        int gap;
        pct = (pace == PACE_SPARSE) ? 76 : (pace == PACE_MIXED) ? 24 : 0;
        gap = 0;
        while (int'($urandom_range(99)) < pct)
            gap++;
        return gap;
    endfunction

    // Drive one command beat; entered and left at a falling edge
    task automatic send_cmd(input cmd_t c, input int gap, input logic typed,
                            input res_t typed_res);
        res_t r;
        if (gap > 0)
        begin
            // idle only while the block could take a beat
            start <= 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        lru_lookup(c, r);
        pending_res.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected beat has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_res.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_limit = lim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_res.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result beat %h", result);
            end
            else
            begin
                want = pending_res.pop_front();
                if (result.hit !== want.hit)
                    flag_mismatch("hit", KEY_W'(want.hit), KEY_W'(result.hit));
                if (result.slot !== want.slot)
                    flag_mismatch("slot", KEY_W'(want.slot), KEY_W'(result.slot));
                if (result.evicted !== want.evicted)
                    flag_mismatch("evicted", KEY_W'(want.evicted), KEY_W'(result.evicted));
                if (result.evicted_key !== want.evicted_key)
                    flag_mismatch("evicted_key", want.evicted_key, result.evicted_key);
            end
        end
    end

    // Stop the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cmd_t                c;
        int                  pool_n;
        logic [KEY_W-1:0]    pool [32];
        logic [LIMIT_W-1:0]  lim;
        pace_t               pace;
        step_t               s;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        err_count   = 0;
        idle_cycles = 0;
        shadow_count = '0;
        shadow_limit = OPEN_LIMIT_RESET;
        for (int i = 0; i < 2*TABLE_ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_stamp[i] = '0;
        end

        // directed: extremes, hits, eviction over the limit, full table, lowest slot
        plan.push_back(typed_row(OP_READ,  32'h0000_0000, 1'b0, 4'd0, 1'b0, '0));
        plan.push_back(typed_row(OP_READ,  32'hFFFF_FFFF, 1'b0, 4'd1, 1'b0, '0));
        plan.push_back(typed_row(OP_READ,  32'h0000_0000, 1'b1, 4'd0, 1'b0, '0));
        plan.push_back(typed_row(OP_WRITE, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0, '0));
        plan.push_back(typed_row(OP_WRITE, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0, '0));
        for (int k = 2; k <= 9; k++)
            plan.push_back(cmd_row(OP_READ, KEY_W'(k)));
        plan.push_back(cmd_row(OP_READ, 32'h8000_0000));
        plan.push_back(cmd_row(OP_READ, 32'hA5A5_A5A5));
        plan.push_back(cmd_row(OP_READ, 32'h5A5A_5A5A));
        plan.push_back(cfg_row(4'd15));
        for (int k = 'h11; k <= 'h15; k++)
            plan.push_back(cmd_row(OP_READ, KEY_W'(k)));
        plan.push_back(cmd_row(OP_READ, 32'h7FFF_FFFF));
        plan.push_back(cmd_row(OP_READ, 32'h0000_0002));
        plan.push_back(cfg_row(4'd0));
        plan.push_back(typed_row(OP_WRITE, 32'h0000_0001, 1'b0, 4'd0, 1'b1, 32'hFFFF_FFFF));
        plan.push_back(typed_row(OP_WRITE, 32'h0000_0001, 1'b1, 4'd0, 1'b0, '0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        foreach (plan[i])
        begin
            s = plan[i];
            if (s.is_cfg)
                write_limit(s.limit);
            else
                send_cmd(s.cmd, 0, s.typed, s.res);
        end

        // randomized phases over limits and pacing
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0, 6:    lim = 4'd15;
                1, 7:    lim = 4'd0;
                2:       lim = OPEN_LIMIT_RESET;
                4:       lim = 4'd1;
                default: lim = LIMIT_W'($urandom_range(15));
            endcase
            write_limit(lim);
            pace   = (p % 3 == 1) ? PACE_SPARSE : (p % 3 == 2) ? PACE_MIXED : PACE_FULL;
            pool_n = $urandom_range(10, 32);
            for (int k = 0; k < pool_n; k++)
                pool[k] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly keys from a small set, so hits and evictions recur
                c.opcode = 1'($urandom_range(1));
                if ($urandom_range(99) < 85)
                    c.table_key = pool[5'($urandom_range(pool_n - 1))];
                else
                    c.table_key = $urandom;
                if (n == PHASE_ITEMS / 2 || $urandom_range(99) == 0)
                    drain_results();
                send_cmd(c, draw_gap(pace), 1'b0, '0);
            end
        end

        // let the last beats come home
        drain_results();
        repeat (TABLE_ENTRIES + 4) @(posedge clk);
        if (pending_res.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/tlht_pkg.sv
rtl/tlht_store.sv
rtl/tlht_scan.sv
rtl/tlht_ctrl.sv
rtl/timestamp_lru_handle_table.sv
test/tb_top.sv
